// File: src/pdpe_pkg.sv
`timescale 1ns / 1ps

package pdpe_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [9:0] off_t;

  // fixed layout of the compressed buffer
  localparam int HEADER_BYTES = 2;
  localparam int TRIPLE_BYTES = 3;

  // descriptor queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // byte slots of one entry, in output order
  localparam int NUM_SLOTS = 7;
  localparam logic [2:0] SLOT_SKIP   = 3'd0;
  localparam logic [2:0] SLOT_RED    = 3'd1;
  localparam logic [2:0] SLOT_GREEN  = 3'd2;
  localparam logic [2:0] SLOT_BLUE   = 3'd3;
  localparam logic [2:0] SLOT_CLOSE  = 3'd4;
  localparam logic [2:0] SLOT_HDR_LO = 3'd5;
  localparam logic [2:0] SLOT_HDR_HI = 3'd6;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  // work for the back end produced from one accepted entry
  typedef struct packed {
    logic  skip_en;
    logic  trip_en;
    logic  close_en;
    logic  hdr_en;
    byte_t skip_val;
    off_t  skip_off;
    byte_t red;
    byte_t green;
    byte_t blue;
    off_t  trip_off;
    off_t  close_off;
    byte_t close_val;
    byte_t pkt_cnt;
    off_t  total_len;
  } desc_t;

endpackage

// File: src/pdpe_if.sv
`timescale 1ns / 1ps

// palette entry channel
interface pdpe_in_if import pdpe_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t old_red;
  byte_t old_green;
  byte_t old_blue;
  byte_t new_red;
  byte_t new_green;
  byte_t new_blue;
  logic  is_final;

  modport source (
    output valid, old_red, old_green, old_blue, new_red, new_green, new_blue, is_final,
    input  ready
  );
  modport sink (
    input  valid, old_red, old_green, old_blue, new_red, new_green, new_blue, is_final,
    output ready
  );
endinterface

// addressed byte channel
interface pdpe_out_if import pdpe_pkg::*; ();
  logic  valid;
  logic  ready;
  off_t  byte_offset;
  byte_t byte_value;
  off_t  total_length;
  logic  end_of_run;

  modport source (
    output valid, byte_offset, byte_value, total_length, end_of_run,
    input  ready
  );
  modport sink (
    input  valid, byte_offset, byte_value, total_length, end_of_run,
    output ready
  );
endinterface

// File: src/palette_delta_packet_encoder.sv
`timescale 1ns / 1ps

// channel   | dir | handshake           | payload
// ----------+-----+---------------------+-----------------------------------------
// in_ch     | in  | valid/ready         | old and new rgb bytes, is_final
// out_ch    | out | valid/ready         | byte_offset, byte_value, total_length,
//           |     |                     | end_of_run
//
// one output byte per cycle from the back end while the output is ready; an entry
// writes one to seven bytes (four for a non-final entry that opens a packet), and
// an entry writing nothing is taken without a push to the queue
// the front end takes an entry per cycle while the four-deep descriptor queue
// has room; the byte output port sets the sustained rate
// synchronous active-low reset clears encoder state, queue and output valid
// a stalled output holds its byte; the queue lets input run on meanwhile

module palette_delta_packet_encoder import pdpe_pkg::*; #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  pdpe_in_if.sink     in_ch,
  pdpe_out_if.source  out_ch
);

  logic  push;
  desc_t push_desc;
  logic  pop;
  desc_t head;
  logic  q_full;
  logic  q_empty;

  pdpe_front #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  pdpe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  pdpe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// File: src/pdpe_front.sv
`timescale 1ns / 1ps

module pdpe_front import pdpe_pkg::*; #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic   clk,
  input  logic   rst_n,
  pdpe_in_if.sink in_ch,
  input  logic   q_full,
  output logic   push,
  output desc_t  push_desc
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  typedef logic [CW-1:0] cnt_t;
  localparam cnt_t CNT_MAX = CW'(MAX_ENTRIES);

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v < CNT_MAX) ? cnt_t'(v + 1'b1) : CNT_MAX;
  endfunction

  logic  run_r, run_nxt;
  cnt_t  skip_r, skip_nxt;
  cnt_t  chg_r, chg_nxt;
  off_t  wp_r, wp_nxt;
  off_t  cbp_r, cbp_nxt;
  byte_t pkt_r, pkt_nxt;

  logic  changed;
  logic  take;
  off_t  wp_t;
  cnt_t  chg_t;
  cnt_t  skip_t;
  desc_t d;

  assign changed = (in_ch.old_red   != in_ch.new_red)
                || (in_ch.old_green != in_ch.new_green)
                || (in_ch.old_blue  != in_ch.new_blue);

  assign in_ch.ready = !q_full;
  assign take        = in_ch.valid && in_ch.ready;

  // classify entry and work out packet bytes
  always_comb begin
    d         = '0;
    d.red     = in_ch.new_red;
    d.green   = in_ch.new_green;
    d.blue    = in_ch.new_blue;
    run_nxt   = run_r;
    skip_nxt  = skip_r;
    chg_nxt   = chg_r;
    wp_nxt    = wp_r;
    cbp_nxt   = cbp_r;
    pkt_nxt   = pkt_r;
    wp_t      = wp_r;
    chg_t     = chg_r;
    skip_t    = skip_r;

    if (changed) begin
      if (!run_r) begin
        // open a packet: skip byte now, count byte later
        d.skip_en  = 1'b1;
        d.skip_val = 8'(skip_r);
        d.skip_off = wp_r;
        cbp_nxt    = wp_r + off_t'(1);
        wp_t       = wp_r + off_t'(2);
        pkt_nxt    = pkt_r + 8'd1;
        chg_t      = '0;
        skip_nxt   = '0;
        run_nxt    = 1'b1;
      end
      d.trip_en  = 1'b1;
      d.trip_off = wp_t;
      wp_nxt     = wp_t + off_t'(TRIPLE_BYTES);
      chg_nxt    = sat_inc(chg_t);
    end else begin
      if (run_r) begin
        // run closed: fill in its count byte
        d.close_en  = 1'b1;
        d.close_off = cbp_r;
        d.close_val = 8'(chg_r);
        run_nxt     = 1'b0;
        skip_t      = '0;
      end
      skip_nxt = sat_inc(skip_t);
    end

    if (in_ch.is_final) begin
      if (run_nxt) begin
        d.close_en  = 1'b1;
        d.close_off = cbp_nxt;
        d.close_val = 8'(chg_nxt);
      end
      d.hdr_en    = 1'b1;
      d.pkt_cnt   = pkt_nxt;
      d.total_len = wp_nxt;
      // new map starts afresh
      run_nxt  = 1'b0;
      skip_nxt = '0;
      chg_nxt  = '0;
      wp_nxt   = off_t'(HEADER_BYTES);
      cbp_nxt  = '0;
      pkt_nxt  = '0;
    end
  end

  assign push      = take && (d.skip_en || d.trip_en || d.close_en || d.hdr_en);
  assign push_desc = d;

  // encoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      skip_r <= '0;
      chg_r  <= '0;
      wp_r   <= off_t'(HEADER_BYTES);
      cbp_r  <= '0;
      pkt_r  <= '0;
    end else if (take) begin
      run_r  <= run_nxt;
      skip_r <= skip_nxt;
      chg_r  <= chg_nxt;
      wp_r   <= wp_nxt;
      cbp_r  <= cbp_nxt;
      pkt_r  <= pkt_nxt;
    end
  end

endmodule

// File: src/pdpe_queue.sv
`timescale 1ns / 1ps

module pdpe_queue import pdpe_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output desc_t head,
  output logic  full,
  output logic  empty
);

  desc_t            mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     cnt_r;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_ptr_r];

  // descriptor storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: src/pdpe_back.sv
`timescale 1ns / 1ps

module pdpe_back import pdpe_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  desc_t        head,
  input  logic         q_empty,
  output logic         pop,
  pdpe_out_if.source   out_ch
);

  desc_t      cur_r;
  slot_mask_t mask_r;

  logic       out_valid_r;
  off_t       out_off_r;
  byte_t      out_val_r;
  off_t       out_total_r;
  logic       out_end_r;

  logic       use_head;
  desc_t      eff_d;
  slot_mask_t eff_m;
  slot_mask_t low;
  slot_mask_t rem;
  logic [2:0] slot;
  logic       can_load;
  logic       go;
  off_t       sel_off;
  byte_t      sel_val;
  logic       sel_last;

  function automatic slot_mask_t mask_of(input desc_t d);
    slot_mask_t m;
    m              = '0;
    m[SLOT_SKIP]   = d.skip_en;
    m[SLOT_RED]    = d.trip_en;
    m[SLOT_GREEN]  = d.trip_en;
    m[SLOT_BLUE]   = d.trip_en;
    m[SLOT_CLOSE]  = d.close_en;
    m[SLOT_HDR_LO] = d.hdr_en;
    m[SLOT_HDR_HI] = d.hdr_en;
    return m;
  endfunction

  // current descriptor, or the queue head once it is used up
  assign use_head = (mask_r == '0);
  assign eff_d    = use_head ? head : cur_r;
  assign eff_m    = use_head ? (q_empty ? '0 : mask_of(head)) : mask_r;
  assign low      = eff_m & (~eff_m + 1'b1);
  assign rem      = eff_m & ~low;

  assign can_load = !out_valid_r || out_ch.ready;
  assign go       = can_load && (eff_m != '0);
  assign pop      = go && use_head;

  // one-hot pick to slot number
  always_comb begin
    slot = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (low[i]) begin
        slot = 3'(i);
      end
    end
  end

  // byte for the chosen slot
  always_comb begin
    sel_last = 1'b0;
    case (slot)
      SLOT_SKIP: begin
        sel_off = eff_d.skip_off;
        sel_val = eff_d.skip_val;
      end
      SLOT_RED: begin
        sel_off = eff_d.trip_off;
        sel_val = eff_d.red;
      end
      SLOT_GREEN: begin
        sel_off = eff_d.trip_off + off_t'(1);
        sel_val = eff_d.green;
      end
      SLOT_BLUE: begin
        sel_off = eff_d.trip_off + off_t'(2);
        sel_val = eff_d.blue;
      end
      SLOT_CLOSE: begin
        sel_off = eff_d.close_off;
        sel_val = eff_d.close_val;
      end
      SLOT_HDR_LO: begin
        sel_off = off_t'(0);
        sel_val = eff_d.pkt_cnt;
      end
      SLOT_HDR_HI: begin
        sel_off  = off_t'(1);
        sel_val  = '0;
        sel_last = 1'b1;
      end
      default: begin
        sel_off = '0;
        sel_val = '0;
      end
    endcase
  end

  // descriptor progress
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (go) begin
      mask_r <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      cur_r <= eff_d;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (can_load) begin
      out_valid_r <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_off_r   <= sel_off;
      out_val_r   <= sel_val;
      out_total_r <= sel_last ? eff_d.total_len : '0;
      out_end_r   <= sel_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.byte_offset  = out_off_r;
  assign out_ch.byte_value   = out_val_r;
  assign out_ch.total_length = out_total_r;
  assign out_ch.end_of_run   = out_end_r;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pdpe_pkg::*;

  localparam int PALETTE_MAX  = 256;
  localparam int TOTAL_ITEMS  = 410;
  localparam int LONG_RUN     = 341;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES  = 250;

  // one palette entry as offered on the input channel
  typedef struct {
    byte_t old_r, old_g, old_b;
    byte_t new_r, new_g, new_b;
    logic  fin;
  } pal_entry_t;

  // one addressed byte of the compressed buffer
  typedef struct {
    off_t  offset;
    byte_t value;
    off_t  total;
    logic  last;
  } buf_byte_t;

  logic clk;
  logic rst_n;

  pdpe_in_if  in_ch ();
  pdpe_out_if out_ch ();

  palette_delta_packet_encoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pal_entry_t pending_entries[$];
  buf_byte_t  expected_bytes[$];

  int entries_queued = 0;
  int entries_sent   = 0;
  int entries_taken  = 0;
  int mismatch_count = 0;
  int hold_left      = 0;
  bit hold_done      = 0;

  // encoder state mirror
  logic  run_open;
  int    skip_cnt;
  int    chg_cnt;
  off_t  wr_ptr;
  off_t  cnt_pos;
  byte_t pkt_cnt;

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int sat_inc(int v);
    return (v < PALETTE_MAX) ? v + 1 : PALETTE_MAX;
  endfunction

  function void clear_encoder();
    run_open = 1'b0;
    skip_cnt = 0;
    chg_cnt  = 0;
    wr_ptr   = off_t'(HEADER_BYTES);
    cnt_pos  = '0;
    pkt_cnt  = '0;
  endfunction

  function void emit_byte(off_t off, byte_t val, off_t total = '0, logic last = 1'b0);
    buf_byte_t b;
    b.offset = off;
    b.value  = val;
    b.total  = total;
    b.last   = last;
    expected_bytes.push_back(b);
  endfunction

  // bytes written for one accepted entry, in output order
  function void encode_entry(pal_entry_t e);
    logic changed;
    changed = (e.old_r != e.new_r) || (e.old_g != e.new_g) || (e.old_b != e.new_b);
    if (changed) begin
      // opening a packet: skip byte, room for the count byte
      if (!run_open) begin
        emit_byte(wr_ptr, byte_t'(skip_cnt));
        cnt_pos  = wr_ptr + off_t'(1);
        wr_ptr   = wr_ptr + off_t'(2);
        pkt_cnt  = pkt_cnt + byte_t'(1);
        chg_cnt  = 0;
        skip_cnt = 0;
        run_open = 1'b1;
      end
      emit_byte(wr_ptr, e.new_r);
      emit_byte(wr_ptr + off_t'(1), e.new_g);
      emit_byte(wr_ptr + off_t'(2), e.new_b);
      wr_ptr  = wr_ptr + off_t'(TRIPLE_BYTES);
      chg_cnt = sat_inc(chg_cnt);
    end else begin
      // an unchanged entry closes any open run
      if (run_open) begin
        emit_byte(cnt_pos, byte_t'(chg_cnt));
        run_open = 1'b0;
        skip_cnt = 0;
      end
      skip_cnt = sat_inc(skip_cnt);
    end
    // last entry: close the run, write the header, report the length
    if (e.fin) begin
      if (run_open) emit_byte(cnt_pos, byte_t'(chg_cnt));
      emit_byte(off_t'(0), pkt_cnt);
      emit_byte(off_t'(1), byte_t'(0), wr_ptr, 1'b1);
      clear_encoder();
    end
  endfunction

  function void add_raw(logic [23:0] old_rgb, logic [23:0] new_rgb, logic fin);
    pal_entry_t e;
    {e.old_r, e.old_g, e.old_b} = old_rgb;
    {e.new_r, e.new_g, e.new_b} = new_rgb;
    e.fin = fin;
    pending_entries.push_back(e);
    entries_queued++;
  endfunction

  // random old triple; a changed entry flips a random non-empty subset of bytes
  function void add_random(bit changed, logic fin);
    logic [23:0] old_rgb;
    logic [23:0] new_rgb;
    logic [2:0]  mask;
    old_rgb = 24'($urandom);
    new_rgb = old_rgb;
    if (changed) begin
      mask = 3'($urandom_range(1, 7));
      if (mask[2]) new_rgb[23:16] ^= 8'($urandom_range(1, 255));
      if (mask[1]) new_rgb[15:8]  ^= 8'($urandom_range(1, 255));
      if (mask[0]) new_rgb[7:0]   ^= 8'($urandom_range(1, 255));
    end
    add_raw(old_rgb, new_rgb, fin);
  endfunction

  // stimulus, reset and end of run
  initial begin
    int len;
    int density;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.old_red   = '0;
    in_ch.old_green = '0;
    in_ch.old_blue  = '0;
    in_ch.new_red   = '0;
    in_ch.new_green = '0;
    in_ch.new_blue  = '0;
    in_ch.is_final  = 1'b0;
    out_ch.ready    = 1'b0;
    clear_encoder();

    // all-equal palette of one entry: zero header, length 2
    add_raw(24'h000000, 24'h000000, 1'b1);
    // one changed entry, extremes of every byte
    add_raw(24'h000000, 24'hffffff, 1'b1);
    // single-byte changes, a gap, trailing unchanged entries dropped
    add_raw(24'hffffff, 24'hffffff, 1'b0);
    add_raw(24'hffffff, 24'h00ffff, 1'b0);
    add_raw(24'h00ff00, 24'h000000, 1'b0);
    add_raw(24'h123456, 24'h123456, 1'b0);
    add_raw(24'h0000ff, 24'h000000, 1'b0);
    add_raw(24'haaaaaa, 24'haaaaaa, 1'b0);
    add_raw(24'h555555, 24'h555555, 1'b1);
    // longer all-equal palette
    add_raw(24'hffffff, 24'hffffff, 1'b0);
    add_raw(24'h800000, 24'h800000, 1'b0);
    add_raw(24'h000001, 24'h000001, 1'b1);
    // run closed by an unchanged final entry
    add_raw(24'h010203, 24'hfefdfc, 1'b0);
    add_raw(24'h7f7f7f, 24'h7f7f7f, 1'b1);
    // run still open at the final entry
    add_raw(24'h80ff01, 24'h7f00fe, 1'b0);
    add_raw(24'hffffff, 24'hfffffe, 1'b1);

    // oversized map: one long run, change count saturates and offsets wrap
    for (int i = 0; i < LONG_RUN; i++) add_random(1'b1, logic'(i == LONG_RUN - 1));

    // random maps of mostly small size and varied change density
    while (entries_queued < TOTAL_ITEMS) begin
      len = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 60);
      density = $urandom_range(0, 100);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 10)
          add_raw(24'($urandom), 24'($urandom), logic'(i == len - 1));
        else
          add_random($urandom_range(99) < density, logic'(i == len - 1));
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (entries_taken != entries_queued || expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // timeout
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // entry driver: holds an entry until its transfer, then offers the next
  always @(negedge clk) begin
    int ph;
    pal_entry_t e;
    bit idle;
    ph = (entries_taken / 100) % 4;
    idle = (ph == 1) ? ($urandom_range(99) < 69) :
           (ph == 3) ? ($urandom_range(99) < 17) : 1'b0;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && entries_taken != entries_sent) begin
      // transfer still pending, hold
    end else if (pending_entries.size() != 0 && !idle) begin
      e = pending_entries.pop_front();
      in_ch.old_red   <= e.old_r;
      in_ch.old_green <= e.old_g;
      in_ch.old_blue  <= e.old_b;
      in_ch.new_red   <= e.new_r;
      in_ch.new_green <= e.new_g;
      in_ch.new_blue  <= e.new_b;
      in_ch.is_final  <= e.fin;
      in_ch.valid     <= 1'b1;
      entries_sent++;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // long receiver hold-off so the descriptor queue fills and input stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && entries_taken >= 30) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // byte receiver ready
  always @(negedge clk) begin
    int ph;
    bit stall;
    ph = (entries_taken / 100) % 4;
    stall = (ph == 2) ? ($urandom_range(99) < 69) :
            (ph == 3) ? ($urandom_range(99) < 17) : 1'b0;
    if (!rst_n) out_ch.ready <= 1'b0;
    else        out_ch.ready <= (hold_left == 0) && !stall;
  end

  // monitor: predict on each entry transfer, check each byte transfer
  always @(posedge clk) begin
    pal_entry_t e;
    buf_byte_t  exp_b;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        e.old_r = in_ch.old_red;
        e.old_g = in_ch.old_green;
        e.old_b = in_ch.old_blue;
        e.new_r = in_ch.new_red;
        e.new_g = in_ch.new_green;
        e.new_b = in_ch.new_blue;
        e.fin   = in_ch.is_final;
        encode_entry(e);
        entries_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte: offset %0d value %0d length %0d end %0b",
                   $time, out_ch.byte_offset, out_ch.byte_value,
                   out_ch.total_length, out_ch.end_of_run);
          mismatch_count++;
        end else begin
          exp_b = expected_bytes.pop_front();
          if (out_ch.byte_offset !== exp_b.offset || out_ch.byte_value !== exp_b.value ||
              out_ch.total_length !== exp_b.total || out_ch.end_of_run !== exp_b.last) begin
            $display("%0t: byte mismatch: expected offset %0d value %0d length %0d end %0b,",
                     $time, exp_b.offset, exp_b.value, exp_b.total, exp_b.last);
            $display("%0t:   actual offset %0d value %0d length %0d end %0b",
                     $time, out_ch.byte_offset, out_ch.byte_value,
                     out_ch.total_length, out_ch.end_of_run);
            mismatch_count++;
          end
        end
      end
    end
  end

endmodule

// File: filelist.f
src/pdpe_pkg.sv
src/pdpe_if.sv
src/pdpe_front.sv
src/pdpe_queue.sv
src/pdpe_back.sv
src/palette_delta_packet_encoder.sv
bench/testbench.sv
